[design/rcof_pkg.sv]
// ----------------------------------------------------------------------------
// rcof_pkg
// Shared types and constants of the radio-control channel outlier filter.
// ----------------------------------------------------------------------------
package rcof_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned WINDOW_DEFAULT = 3;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd750;
  localparam logic [CFG_W-1:0] LOW_LIMIT_RESET = 16'd500;
  localparam logic [CFG_W-1:0] HIGH_LIMIT_RESET = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTLIER_THRESHOLD = 2'd0,
    CFG_MODE_LOW_LIMIT    = 2'd1,
    CFG_MODE_HIGH_LIMIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_EXECUTE = 2'd0,
    MODE_LAND    = 2'd1,
    MODE_HOLD    = 2'd2
  } flight_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] clean_a;
    logic [SAMPLE_W-1:0] clean_b;
    logic [SAMPLE_W-1:0] clean_c;
    logic                swapped_a;
    logic                swapped_b;
    logic                swapped_c;
    flight_mode_e        flight_mode;
  } out_t;

endpackage

[design/rc_channel_outlier_filter.sv]
// ----------------------------------------------------------------------------
// rc_channel_outlier_filter
// Three-channel sliding-window outlier filter with flight mode selection.
// ----------------------------------------------------------------------------
// Accepts one frame of three channel samples per cycle and returns one result
// per frame: the frame is held in an input register, filtered in a single
// combinational pass (window sum, distance test, reciprocal-multiply mean,
// mode compare) and captured in a result register. Throughput is one frame
// per clock as long as results are taken. The first WINDOW-1 frames after
// reset pass unchanged; from then on a sample farther than the threshold from
// the window mean is replaced by the floored mean. The user must write
// registers through the write port only while no frame is in flight; the
// block itself does not enforce this.
module rc_channel_outlier_filter #(
  parameter int unsigned WINDOW = rcof_pkg::WINDOW_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcof_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcof_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rcof_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rcof_pkg::out_t                 out_data_o
);
  import rcof_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);

  logic [CFG_W-1:0]    threshold_q;
  logic [CFG_W-1:0]    low_limit_q;
  logic [CFG_W-1:0]    high_limit_q;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                s1_valid_q;
  in_t                 s1_data_q;
  logic                out_valid_q;
  out_t                out_data_q, out_data_d;
  logic                s1_adv;
  logic                full;
  logic [SAMPLE_W-1:0] clean_a;
  logic [SAMPLE_W-1:0] clean_b;
  logic [SAMPLE_W-1:0] clean_c;
  logic                swapped_a;
  logic                swapped_b;
  logic                swapped_c;
  flight_mode_e        flight_mode;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign full       = fill_q >= FILL_W'(WINDOW - 1);
  assign fill_d     = (fill_q == FILL_W'(WINDOW)) ? fill_q : fill_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RESET;
      low_limit_q  <= LOW_LIMIT_RESET;
      high_limit_q <= HIGH_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUTLIER_THRESHOLD: threshold_q  <= cfg_data_i;
        CFG_MODE_LOW_LIMIT:    low_limit_q  <= cfg_data_i;
        CFG_MODE_HIGH_LIMIT:   high_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  rcof_chan_filter #(.WINDOW(WINDOW)) u_chan_a (
    .clk_i       (clk_i),
    .shift_i     (s1_adv),
    .full_i      (full),
    .threshold_i (threshold_q),
    .sample_i    (s1_data_q.sample_a),
    .clean_o     (clean_a),
    .swapped_o   (swapped_a)
  );

  rcof_chan_filter #(.WINDOW(WINDOW)) u_chan_b (
    .clk_i       (clk_i),
    .shift_i     (s1_adv),
    .full_i      (full),
    .threshold_i (threshold_q),
    .sample_i    (s1_data_q.sample_b),
    .clean_o     (clean_b),
    .swapped_o   (swapped_b)
  );

  rcof_chan_filter #(.WINDOW(WINDOW)) u_chan_c (
    .clk_i       (clk_i),
    .shift_i     (s1_adv),
    .full_i      (full),
    .threshold_i (threshold_q),
    .sample_i    (s1_data_q.sample_c),
    .clean_o     (clean_c),
    .swapped_o   (swapped_c)
  );

  // Low limit wins when the limits cross.
  always_comb begin
    priority if (clean_c < low_limit_q) begin
      flight_mode = MODE_EXECUTE;
    end else if (clean_c > high_limit_q) begin
      flight_mode = MODE_LAND;
    end else begin
      flight_mode = MODE_HOLD;
    end
  end

  assign out_data_d = '{
    clean_a:     clean_a,
    clean_b:     clean_b,
    clean_c:     clean_c,
    swapped_a:   swapped_a,
    swapped_b:   swapped_b,
    swapped_c:   swapped_c,
    flight_mode: flight_mode
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[design/rcof_chan_filter.sv]
// ----------------------------------------------------------------------------
// rcof_chan_filter
// Sample history and outlier test of one channel: window sum, distance test
// against the scaled threshold and floored mean by reciprocal multiplication.
// ----------------------------------------------------------------------------
module rcof_chan_filter #(
  parameter int unsigned WINDOW = rcof_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic                          full_i,
  input  logic [rcof_pkg::CFG_W-1:0]    threshold_i,
  input  logic [rcof_pkg::SAMPLE_W-1:0] sample_i,
  output logic [rcof_pkg::SAMPLE_W-1:0] clean_o,
  output logic                          swapped_o
);
  import rcof_pkg::*;

  localparam int unsigned LOG_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_W + LOG_W;
  localparam int unsigned DIV_SH = SUM_W + LOG_W;
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  localparam int unsigned HIST_N = (WINDOW > 1) ? WINDOW - 1 : 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SAMPLE_W-1:0] hist_q [HIST_N];
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    scaled;
  logic [SUM_W-1:0]    thr_scaled;
  logic [SUM_W-1:0]    gap;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] mean;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < HIST_N; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_comb begin
    sum = SUM_W'(sample_i);
    for (int i = 0; i < WINDOW - 1; i++) begin
      sum = sum + SUM_W'(hist_q[i]);
    end
  end

  assign scaled     = SUM_W'(WINDOW) * SUM_W'(sample_i);
  assign thr_scaled = SUM_W'(WINDOW) * SUM_W'(threshold_i);
  assign gap        = (scaled > sum) ? (scaled - sum) : (sum - scaled);
  assign prod       = PROD_W'(sum) * PROD_W'(RECIP);
  assign mean       = prod[DIV_SH +: SAMPLE_W];

  assign swapped_o = full_i && (gap > thr_scaled);
  assign clean_o   = swapped_o ? mean : sample_i;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-channel outlier filter.
// ----------------------------------------------------------------------------
// Frames are driven over the valid/ready input channel with random idle
// bursts, and results are taken with random stalls. A scoreboard keeps its
// own sliding windows and register copies, predicts every result frame and
// compares each field in order. A directed part covers the fill phase, the
// exact threshold, the mode limits and the register extremes; random phases
// then run under several register settings, the last one without idling.
// ----------------------------------------------------------------------------

class clean_frame_sb;
  localparam int unsigned WIN = rcof_pkg::WINDOW_DEFAULT;

  logic [15:0]    history [3][WIN];
  int unsigned    frames_seen;
  logic [15:0]    threshold;
  logic [15:0]    low_limit;
  logic [15:0]    high_limit;
  rcof_pkg::out_t clean_q [$];
  int unsigned    errors;

  function new();
    frames_seen = 0;
    errors      = 0;
    threshold   = rcof_pkg::THRESHOLD_RESET;
    low_limit   = rcof_pkg::LOW_LIMIT_RESET;
    high_limit  = rcof_pkg::HIGH_LIMIT_RESET;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      rcof_pkg::CFG_OUTLIER_THRESHOLD: threshold  = val;
      rcof_pkg::CFG_MODE_LOW_LIMIT:    low_limit  = val;
      rcof_pkg::CFG_MODE_HIGH_LIMIT:   high_limit = val;
      default: ;
    endcase
  endfunction

  function logic [15:0] filter_sample(int ch, logic [15:0] x, output logic swapped);
    longint unsigned sum;
    longint unsigned scaled;
    longint unsigned gap;
    for (int i = 0; i + 1 < WIN; i++) history[ch][i] = history[ch][i+1];
    history[ch][WIN-1] = x;
    swapped = 1'b0;
    if (frames_seen < WIN) return x;
    sum = 0;
    for (int i = 0; i < WIN; i++) sum += longint'(history[ch][i]);
    scaled = longint'(x) * WIN;
    gap    = (scaled > sum) ? scaled - sum : sum - scaled;
    if (gap > longint'(threshold) * WIN) begin
      swapped = 1'b1;
      return 16'(sum / WIN);
    end
    return x;
  endfunction

  function void note_frame(rcof_pkg::in_t f);
    rcof_pkg::out_t e;
    logic [2:0]     sw;
    if (frames_seen < WIN) frames_seen++;
    e.clean_a   = filter_sample(0, f.sample_a, sw[0]);
    e.clean_b   = filter_sample(1, f.sample_b, sw[1]);
    e.clean_c   = filter_sample(2, f.sample_c, sw[2]);
    e.swapped_a = sw[0];
    e.swapped_b = sw[1];
    e.swapped_c = sw[2];
    if (e.clean_c < low_limit) begin
      e.flight_mode = rcof_pkg::MODE_EXECUTE;
    end else if (e.clean_c > high_limit) begin
      e.flight_mode = rcof_pkg::MODE_LAND;
    end else begin
      e.flight_mode = rcof_pkg::MODE_HOLD;
    end
    clean_q = {clean_q, e};
  endfunction

  function void check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      errors++;
    end
  endfunction

  function void check_frame(rcof_pkg::out_t got);
    rcof_pkg::out_t e;
    if (clean_q.size() == 0) begin
      $error("result transaction with no frame outstanding");
      errors++;
      return;
    end
    e = clean_q.pop_front();
    check_field("clean_a", e.clean_a, got.clean_a);
    check_field("clean_b", e.clean_b, got.clean_b);
    check_field("clean_c", e.clean_c, got.clean_c);
    check_field("swapped_a", 16'(e.swapped_a), 16'(got.swapped_a));
    check_field("swapped_b", 16'(e.swapped_b), 16'(got.swapped_b));
    check_field("swapped_c", 16'(e.swapped_c), 16'(got.swapped_c));
    check_field("flight_mode", 16'(e.flight_mode), 16'(got.flight_mode));
  endfunction

  function int unsigned pending();
    return clean_q.size();
  endfunction

  function void close_out();
    if (clean_q.size() != 0) begin
      $error("%0d result transactions never arrived", clean_q.size());
      errors++;
    end
  endfunction
endclass

module tb_top;
  import rcof_pkg::*;

  localparam int unsigned N_PHASES       = 8;
  localparam int unsigned PHASE_FRAMES   = 225;
  localparam int unsigned DRAIN_SLACK    = 4;
  localparam int unsigned END_SLACK      = 10;
  localparam int unsigned WATCHDOG_LIMIT = 500;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;

  clean_frame_sb sb;
  bit            calm;
  int unsigned   quiet_cycles;

  rc_channel_outlier_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_frame(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_frame(out_data_o);
      if (cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20)) @(negedge clk_i);
    end
  end

  task automatic send_frame(in_t f);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = f;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_abc(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    in_t f;
    f.sample_a = a;
    f.sample_b = b;
    f.sample_c = c;
    send_frame(f);
  endtask

  task automatic settle_block();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
  endtask

  task automatic program_regs(int unsigned thr, int unsigned lo, int unsigned hi,
                              bit poke_spare);
    settle_block();
    write_reg(CFG_OUTLIER_THRESHOLD, 16'(thr));
    write_reg(CFG_MODE_LOW_LIMIT, 16'(lo));
    write_reg(CFG_MODE_HIGH_LIMIT, 16'(hi));
    if (poke_spare) write_reg(CFG_IDX_SPARE, 16'($urandom_range(0, 65535)));
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample(logic [15:0] base, int unsigned spread);
    int          v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      else if (v > 65535) v = 65535;
      return 16'(v);
    end else if (r < 85) begin
      return 16'($urandom_range(0, 65535));
    end else if (r < 95) begin
      return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    end
    return base;
  endfunction

  function automatic logic [15:0] pick_base(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 4))
      0:       return 16'(lo);
      1:       return 16'(hi);
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(900, 2100));
    endcase
  endfunction

  initial begin
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    int unsigned spread;
    logic [15:0] base_a;
    logic [15:0] base_b;
    logic [15:0] base_c;

    sb           = new();
    calm         = 1'b0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill phase, exact threshold, mode limit edges at reset settings
    send_abc(16'd0, 16'd65535, 16'd499);
    send_abc(16'd65535, 16'd0, 16'd500);
    send_abc(16'd1000, 16'd1000, 16'd1500);
    send_abc(16'd1000, 16'd1000, 16'd1500);
    send_abc(16'd1000, 16'd1000, 16'd1500);
    send_abc(16'd2125, 16'd2126, 16'd1501);
    send_abc(16'd1000, 16'd1000, 16'd500);
    send_abc(16'd1000, 16'd1000, 16'd499);
    send_abc(16'd65535, 16'd65535, 16'd65535);
    send_abc(16'd0, 16'd0, 16'd0);

    // zero threshold, crossed limits
    program_regs(0, 65535, 0, 1'b0);
    send_abc(16'd65535, 16'd65535, 16'd65535);
    send_abc(16'd65535, 16'd65535, 16'd65535);
    send_abc(16'd65535, 16'd65535, 16'd65535);
    send_abc(16'd65534, 16'd1, 16'd0);
    send_abc(16'd0, 16'd0, 16'd65535);

    // widest threshold and limits
    program_regs(65535, 0, 65535, 1'b1);
    send_abc(16'd0, 16'd65535, 16'd0);
    send_abc(16'd65535, 16'd0, 16'd65535);
    send_abc(16'd0, 16'd65535, 16'd32768);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          thr = THRESHOLD_RESET;
          lo  = LOW_LIMIT_RESET;
          hi  = HIGH_LIMIT_RESET;
        end
        1: begin
          thr = 0;
          lo  = $urandom_range(0, 2000);
          hi  = lo + $urandom_range(0, 2000);
        end
        2: begin
          thr = 65535;
          lo  = 0;
          hi  = 65535;
        end
        3: begin
          thr = $urandom_range(0, 1500);
          hi  = $urandom_range(0, 1500);
          lo  = hi + $urandom_range(1, 1500);
        end
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 3000);
          lo  = $urandom_range(0, 2500);
          hi  = $urandom_range(3000, lo);
        end
      endcase
      program_regs(thr, lo, hi, $urandom_range(0, 1) == 1);
      if (p == N_PHASES - 1) calm = 1'b1;
      spread = (2 * thr + 8 > 32768) ? 32768 : 2 * thr + 8;
      base_a = pick_base(lo, hi);
      base_b = pick_base(lo, hi);
      base_c = pick_base(lo, hi);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if ($urandom_range(0, 39) == 0) base_a = pick_base(lo, hi);
        if ($urandom_range(0, 39) == 0) base_b = pick_base(lo, hi);
        if ($urandom_range(0, 39) == 0) base_c = pick_base(lo, hi);
        send_abc(pick_sample(base_a, spread), pick_sample(base_b, spread),
                 pick_sample(base_c, spread));
      end
    end

    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[files.f]
design/rcof_pkg.sv
design/rcof_chan_filter.sv
design/rc_channel_outlier_filter.sv
verif/tb_top.sv
